// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared sorted priority queue types: cell control, request kind and status.
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef enum logic [1:0] {
    SPQ_OP_HOLD,
    SPQ_OP_ENQ,
    SPQ_OP_DEQ
  } spq_op_e;

  typedef enum logic [1:0] {
    SPQ_ST_OK,
    SPQ_ST_EMPTY,
    SPQ_ST_FULL
  } spq_status_e;

  typedef enum logic {
    SPQ_REQ_ENQ,
    SPQ_REQ_DEQ
  } spq_req_e;

  typedef struct packed {
    spq_op_e op;
  } spq_ctrl_t;

endpackage

// ===== design/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds, takes the new entry, or takes a
// neighbor's entry, and reports whether the new entry sorts before it.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
#(
  parameter int DATA_WIDTH = 8,
  parameter int PRIO_WIDTH = 16
) (
  input  logic                  clk_i,
  input  spq_ctrl_t             ctrl_i,
  input  logic                  valid_i,
  input  logic [DATA_WIDTH-1:0] new_data_i,
  input  logic [PRIO_WIDTH-1:0] new_prio_i,
  input  logic                  left_lt_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic [PRIO_WIDTH-1:0] left_prio_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  input  logic [PRIO_WIDTH-1:0] right_prio_i,
  output logic                  lt_o,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [PRIO_WIDTH-1:0] prio_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [PRIO_WIDTH-1:0] prio_q, prio_d;

  assign lt_o = !valid_i || (prio_q < new_prio_i);

  always_comb begin
    data_d = data_q;
    prio_d = prio_q;
    unique case (ctrl_i.op)
      SPQ_OP_ENQ: begin
        if (left_lt_i) begin
          data_d = left_data_i;
          prio_d = left_prio_i;
        end else if (lt_o) begin
          data_d = new_data_i;
          prio_d = new_prio_i;
        end
      end
      SPQ_OP_DEQ: begin
        data_d = right_data_i;
        prio_d = right_prio_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign data_o = data_q;
  assign prio_o = prio_q;

endmodule

// ===== design/sorted_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded priority queue kept sorted by descending priority in a cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel carries requests: tuser is the request kind (enqueue or
//   dequeue), tdata holds the data word and its priority. Master channel
//   returns one result transaction per request: tuser is the status, tdata
//   holds the removed data, head data, head priority and entry count.
//   For each request every cell compares its priority with the incoming
//   one in parallel and shifts or loads in the same clock edge.
//   The result is registered and appears the cycle after acceptance.
//   A request is accepted every cycle while results are taken; while a result
//   waits on a stalled receiver, the slave side holds tready low.
//   Equal priorities leave in arrival order. Dequeue while empty reports an
//   empty status; enqueue while full drops the entry and reports full.
//   Reset empties the queue and clears the pending result; the slot
//   contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 8,
  parameter int PRIO_WIDTH = 16,
  localparam int CNT_W     = $clog2(DEPTH + 1),
  localparam int IN_W      = DATA_WIDTH + PRIO_WIDTH,
  localparam int IN_TDW    = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W     = 2 * DATA_WIDTH + PRIO_WIDTH + CNT_W,
  localparam int OUT_TDW   = ((OUT_W + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // data_in, priority_in
  input  logic [IN_TDW-1:0]  s_axis_tdata,
  // req_type
  input  logic               s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // removed_data, head_data, head_priority, entry_count
  output logic [OUT_TDW-1:0] m_axis_tdata,
  // status
  output logic [1:0]         m_axis_tuser
);

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [PRIO_WIDTH-1:0] cell_prio [DEPTH];
  logic                  cell_lt   [DEPTH];

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q, out_valid_d;
  spq_status_e           status_q, status_d;
  logic [DATA_WIDTH-1:0] removed_q, removed_d;
  spq_ctrl_t             ctrl;

  logic                  accept;
  logic [DATA_WIDTH-1:0] new_data;
  logic [PRIO_WIDTH-1:0] new_prio;
  logic                  empty;
  logic                  full;
  logic [DATA_WIDTH-1:0] head_data;
  logic [PRIO_WIDTH-1:0] head_prio;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign new_data      = s_axis_tdata[DATA_WIDTH-1:0];
  assign new_prio      = s_axis_tdata[IN_W-1:DATA_WIDTH];
  assign empty         = (count_q == '0);
  assign full          = (count_q == CNT_W'(DEPTH));

  always_comb begin
    ctrl.op     = SPQ_OP_HOLD;
    status_d    = status_q;
    removed_d   = removed_q;
    count_d     = count_q;
    out_valid_d = m_axis_tready ? 1'b0 : out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
      status_d    = SPQ_ST_OK;
      removed_d   = '0;
      if (spq_req_e'(s_axis_tuser) == SPQ_REQ_DEQ) begin
        if (empty) begin
          status_d = SPQ_ST_EMPTY;
        end else begin
          ctrl.op   = SPQ_OP_DEQ;
          removed_d = cell_data[0];
          count_d   = count_q - CNT_W'(1);
        end
      end else begin
        if (full) begin
          status_d = SPQ_ST_FULL;
        end else begin
          ctrl.op = SPQ_OP_ENQ;
          count_d = count_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    removed_q <= removed_d;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  left_lt;
    logic [DATA_WIDTH-1:0] left_data;
    logic [PRIO_WIDTH-1:0] left_prio;
    logic [DATA_WIDTH-1:0] right_data;
    logic [PRIO_WIDTH-1:0] right_prio;

    if (i == 0) begin : g_first
      assign left_lt   = 1'b0;
      assign left_data = '0;
      assign left_prio = '0;
    end else begin : g_inner_left
      assign left_lt   = cell_lt[i-1];
      assign left_data = cell_data[i-1];
      assign left_prio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data = cell_data[i];
      assign right_prio = cell_prio[i];
    end else begin : g_inner_right
      assign right_data = cell_data[i+1];
      assign right_prio = cell_prio[i+1];
    end

    spq_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .PRIO_WIDTH(PRIO_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .valid_i     (count_q > CNT_W'(i)),
      .new_data_i  (new_data),
      .new_prio_i  (new_prio),
      .left_lt_i   (left_lt),
      .left_data_i (left_data),
      .left_prio_i (left_prio),
      .right_data_i(right_data),
      .right_prio_i(right_prio),
      .lt_o        (cell_lt[i]),
      .data_o      (cell_data[i]),
      .prio_o      (cell_prio[i])
    );
  end

  assign head_data = empty ? '0 : cell_data[0];
  assign head_prio = empty ? '0 : cell_prio[0];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = OUT_TDW'({count_q, head_prio, head_data, removed_q});

endmodule
